// File: rtl/voxel_grid_first_point_filter_core_defines.svh
// ----------------------------------------------------------------------------
// voxel grid first point filter assertion macros
// assertion forms used by the filter back module
// ----------------------------------------------------------------------------
`ifndef VOXEL_GRID_FIRST_POINT_FILTER_CORE_DEFINES_SVH
`define VOXEL_GRID_FIRST_POINT_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define VGFP_CHECK(lbl, pre, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (cond)) \
        else $error(msg);

// next-cycle implication
`define VGFP_NEXT(lbl, pre, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (cond)) \
        else $error(msg);

`endif

// File: rtl/vgfp_pkg.sv
// ----------------------------------------------------------------------------
// vgfp_pkg
// constants, codes and types shared by the voxel grid filter modules
// ----------------------------------------------------------------------------
package vgfp_pkg;

    localparam int TABLE_SLOTS_DEF = 65536;
    localparam int KEY_BITS_DEF    = 21;
    localparam int FIFO_DEPTH      = 4;

    localparam int INV_W      = 23;
    localparam int MAX_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 23;
    localparam int POS_W      = 32;
    localparam int REFL_W     = 8;
    localparam int CNT_W      = 16;
    localparam int PROD_W     = 56;
    localparam int FRAC_SHIFT = 26;

    localparam logic [INV_W-1:0] INV_MAX   = 23'd6553600;
    localparam logic [INV_W-1:0] INV_RESET = 23'd655360;
    localparam logic [MAX_W-1:0] MAX_RESET = 16'd65535;

    localparam logic [31:0] HASH_LO = 32'h7F4A7C15;
    localparam logic [31:0] HASH_HI = 32'h9E3779B9;

    localparam logic [CFG_IDX_W-1:0] REG_INV = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX = 4'd1;

    typedef logic [2:0] t_status;

    localparam t_status ST_INSERTED = 3'd0;
    localparam t_status ST_DUP      = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_INVALID  = 3'd3;
    localparam t_status ST_RANGE    = 3'd4;

endpackage

// File: rtl/vgfp_fifo.sv
// ----------------------------------------------------------------------------
// vgfp_fifo
// small register queue between the classify front and the probe back
// ----------------------------------------------------------------------------
module vgfp_fifo
    import vgfp_pkg::*;
#(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    logic [DW-1:0]  r_buf [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != (PTR_W+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/vgfp_front.sv
// ----------------------------------------------------------------------------
// vgfp_front
// quantizes a point to a voxel key, checks it and computes its home slot
// ----------------------------------------------------------------------------
module vgfp_front
    import vgfp_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS),
    parameter int KW          = 3 * KEY_BITS,
    parameter int DW          = 3 + SLOT_W + KW + REFL_W + 3 * POS_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [POS_W-1:0]    i_pos_x,
    input  logic [POS_W-1:0]    i_pos_y,
    input  logic [POS_W-1:0]    i_pos_z,
    input  logic [REFL_W-1:0]   i_reflect,
    input  logic                i_point_valid,
    input  logic [INV_W-1:0]    i_inv,
    input  logic                i_clear_done,
    output logic                o_q_valid,
    input  logic                i_q_ready,
    output logic [DW-1:0]       o_q_data
);

    localparam int KEY_RAW_W = PROD_W - FRAC_SHIFT;

    logic                      w_stall;
    logic                      w_acc;
    logic [INV_W-1:0]          w_inv;

    logic                      r1_v, r2_v, r3_v;
    logic [POS_W-1:0]          r1_x, r1_y, r1_z;
    logic [POS_W-1:0]          r2_x, r2_y, r2_z;
    logic [POS_W-1:0]          r3_x, r3_y, r3_z;
    logic [REFL_W-1:0]         r1_refl, r2_refl, r3_refl;
    logic                      r1_pv, r2_pv;
    logic signed [PROD_W-1:0]  r2_px, r2_py, r2_pz;
    logic signed [PROD_W-1:0]  n_px, n_py, n_pz;

    logic [KEY_RAW_W-1:0]      w_kx, w_ky, w_kz;
    logic                      w_in_range;
    logic [KW-1:0]             w_key;
    logic [63:0]               w_key64;
    logic [63:0]               n_p0;
    logic [31:0]               n_p1, n_p2;
    t_status                   n_pre;
    logic [63:0]               r3_p0;
    logic [31:0]               r3_p1, r3_p2;
    logic [KW-1:0]             r3_key;
    t_status                   r3_pre;

    logic [63:0]               w_h0;
    logic [63:0]               w_h;
    logic [SLOT_W-1:0]         w_slot;

    assign w_stall   = r3_v && !i_q_ready;
    assign o_ready   = !w_stall && i_clear_done;
    assign w_acc     = i_valid && o_ready;
    assign o_q_valid = r3_v;

    // inverse voxel size clamped to its working range
    always_comb begin
        w_inv = i_inv;
        if (i_inv > INV_MAX) begin
            w_inv = INV_MAX;
        end else if (i_inv == '0) begin
            w_inv = INV_W'(1);
        end
    end

    always_comb begin
        n_px = $signed(r1_x) * $signed({1'b0, w_inv});
        n_py = $signed(r1_y) * $signed({1'b0, w_inv});
        n_pz = $signed(r1_z) * $signed({1'b0, w_inv});
    end

    // floor by arithmetic shift, then range check, key pack, status and hash partial products
    always_comb begin
        w_kx = r2_px[PROD_W-1:FRAC_SHIFT];
        w_ky = r2_py[PROD_W-1:FRAC_SHIFT];
        w_kz = r2_pz[PROD_W-1:FRAC_SHIFT];
        w_in_range = ((&w_kx[KEY_RAW_W-1:KEY_BITS-1]) || !(|w_kx[KEY_RAW_W-1:KEY_BITS-1]))
                  && ((&w_ky[KEY_RAW_W-1:KEY_BITS-1]) || !(|w_ky[KEY_RAW_W-1:KEY_BITS-1]))
                  && ((&w_kz[KEY_RAW_W-1:KEY_BITS-1]) || !(|w_kz[KEY_RAW_W-1:KEY_BITS-1]));
        w_key   = {w_kz[KEY_BITS-1:0], w_ky[KEY_BITS-1:0], w_kx[KEY_BITS-1:0]};
        w_key64 = 64'(w_key);
        n_p0    = 64'(w_key64[31:0]) * 64'(HASH_LO);
        n_p1    = 32'(w_key64[31:0] * HASH_HI);
        n_p2    = 32'(w_key64[63:32] * HASH_LO);
        if (!r2_pv) begin
            n_pre = ST_INVALID;
        end else if (!w_in_range) begin
            n_pre = ST_RANGE;
        end else begin
            n_pre = ST_INSERTED;
        end
    end

    // low word of the hash product and its mix
    always_comb begin
        w_h0   = r3_p0 + {r3_p1 + r3_p2, 32'b0};
        w_h    = w_h0 ^ (w_h0 >> 29);
        w_slot = w_h[16 +: SLOT_W];
    end

    assign o_q_data = {r3_pre, w_slot, r3_key, r3_refl, r3_z, r3_y, r3_x};

    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            r1_x    <= i_pos_x;
            r1_y    <= i_pos_y;
            r1_z    <= i_pos_z;
            r1_refl <= i_reflect;
            r1_pv   <= i_point_valid;
            r2_px   <= n_px;
            r2_py   <= n_py;
            r2_pz   <= n_pz;
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_z    <= r1_z;
            r2_refl <= r1_refl;
            r2_pv   <= r1_pv;
            r3_p0   <= n_p0;
            r3_p1   <= n_p1;
            r3_p2   <= n_p2;
            r3_key  <= w_key;
            r3_pre  <= n_pre;
            r3_x    <= r2_x;
            r3_y    <= r2_y;
            r3_z    <= r2_z;
            r3_refl <= r2_refl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (!w_stall) begin
            r1_v <= w_acc;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

endmodule

// File: rtl/vgfp_back.sv
// ----------------------------------------------------------------------------
// vgfp_back
// reset clear sweep, linear probe walk over the voxel table, insert and result register
// ----------------------------------------------------------------------------
`include "voxel_grid_first_point_filter_core_defines.svh"

module vgfp_back
    import vgfp_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS),
    parameter int KW          = 3 * KEY_BITS,
    parameter int DW          = 3 + SLOT_W + KW + REFL_W + 3 * POS_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  logic [DW-1:0]       i_q_data,
    input  logic [MAX_W-1:0]    i_max,
    output logic                o_clear_done,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_status,
    output logic [POS_W-1:0]    o_out_x,
    output logic [POS_W-1:0]    o_out_y,
    output logic [POS_W-1:0]    o_out_z,
    output logic [REFL_W-1:0]   o_out_reflect,
    output logic [CNT_W-1:0]    o_occupied_count
);

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_PROBE = 4'b0100,
        B_OUT   = 4'b1000
    } t_bstate;

    t_bstate            r_state;
    logic [SLOT_W-1:0]  r_clr;
    logic [SLOT_W-1:0]  r_idx;
    logic [KW-1:0]      r_key;
    t_status            r_stat;
    logic [POS_W-1:0]   r_x, r_y, r_z;
    logic [REFL_W-1:0]  r_refl;
    logic [CNT_W-1:0]   r_total;
    logic [KW:0]        r_mem [TABLE_SLOTS];
    logic [KW:0]        r_rdata;
    logic               r_ovalid;
    t_status            r_ostat;
    logic [POS_W-1:0]   r_ox, r_oy, r_oz;
    logic [REFL_W-1:0]  r_orefl;
    logic [CNT_W-1:0]   r_ocnt;

    t_status            w_q_pre;
    logic [SLOT_W-1:0]  w_q_slot;
    logic [KW-1:0]      w_q_key;
    logic [REFL_W-1:0]  w_q_refl;
    logic [POS_W-1:0]   w_q_x, w_q_y, w_q_z;
    logic [SLOT_W-1:0]  w_raddr;
    logic               w_we;
    logic [SLOT_W-1:0]  w_waddr;
    logic [KW:0]        w_wdata;
    logic               w_used;
    logic               w_match;
    logic               w_at_limit;
    logic               w_ins;
    logic               w_out_free;

    assign {w_q_pre, w_q_slot, w_q_key, w_q_refl, w_q_z, w_q_y, w_q_x} = i_q_data;

    assign o_q_ready    = (r_state == B_IDLE);
    assign o_clear_done = (r_state != B_CLEAR);
    assign w_out_free   = !r_ovalid || i_ready;
    assign w_used       = r_rdata[KW];
    assign w_match      = (r_rdata[KW-1:0] == r_key);
    assign w_at_limit   = (r_total >= i_max) || (32'(r_total) >= 32'(TABLE_SLOTS - 1));
    assign w_ins        = (r_state == B_PROBE) && !w_used && !w_at_limit;
    assign w_raddr      = (r_state == B_IDLE) ? w_q_slot : r_idx + 1'b1;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = {1'b1, r_key};
        if (r_state == B_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (w_ins) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == B_IDLE) && i_q_valid) begin
            r_idx  <= w_q_slot;
            r_key  <= w_q_key;
            r_stat <= w_q_pre;
            r_x    <= w_q_x;
            r_y    <= w_q_y;
            r_z    <= w_q_z;
            r_refl <= w_q_refl;
        end else if (r_state == B_PROBE) begin
            if (!w_used) begin
                r_stat <= w_at_limit ? ST_FULL : ST_INSERTED;
            end else if (w_match) begin
                r_stat <= ST_DUP;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if ((r_state == B_OUT) && w_out_free) begin
            r_ostat <= r_stat;
            r_ox    <= r_x;
            r_oy    <= r_y;
            r_oz    <= r_z;
            r_orefl <= r_refl;
            r_ocnt  <= r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_clr    <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == B_OUT) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SLOT_W'(TABLE_SLOTS - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= (w_q_pre == ST_INSERTED) ? B_PROBE : B_OUT;
                    end
                end
                B_PROBE: begin
                    if (w_ins) begin
                        r_total <= r_total + 1'b1;
                    end
                    if (!w_used || w_match) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (w_out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_CLEAR;
                    r_clr   <= '0;
                end
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_ostat;
    assign o_out_x          = r_ox;
    assign o_out_y          = r_oy;
    assign o_out_z          = r_oz;
    assign o_out_reflect    = r_orefl;
    assign o_occupied_count = r_ocnt;

    `VGFP_CHECK(a_clear_no_pop, r_state == B_CLEAR, !o_q_ready && !r_ovalid, "item during clear")
    `VGFP_CHECK(a_total_cap, 1'b1, 32'(r_total) <= 32'(TABLE_SLOTS - 1), "table overfilled")
    `VGFP_NEXT(a_insert_count, w_ins, r_total == $past(r_total) + 1'b1, "count not advanced")
    `VGFP_NEXT(a_out_load, (r_state == B_OUT) && w_out_free, r_ovalid, "result not loaded")

endmodule

// File: rtl/voxel_grid_first_point_filter_core.sv
// ----------------------------------------------------------------------------
// voxel_grid_first_point_filter_core
// keeps the first point of each voxel while room remains and reports every point by status
// ----------------------------------------------------------------------------
// After reset the block sweeps the voxel table once and takes no item until the
// sweep is done; configuration writes are taken at any time. An item passes
// through the quantize and hash front registers and a small queue, then the probe
// unit visits one table slot per cycle on its linear probe walk, one read of the
// table read port per slot, and handles one item at a time; invalid and
// out-of-range points skip the walk.
module voxel_grid_first_point_filter_core
    import vgfp_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [POS_W-1:0]      i_pos_z,
    input  logic [REFL_W-1:0]     i_reflect,
    input  logic                  i_point_valid,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [2:0]            o_status,
    output logic [POS_W-1:0]      o_out_x,
    output logic [POS_W-1:0]      o_out_y,
    output logic [POS_W-1:0]      o_out_z,
    output logic [REFL_W-1:0]     o_out_reflect,
    output logic [CNT_W-1:0]      o_occupied_count
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int KW     = 3 * KEY_BITS;
    localparam int DW     = 3 + SLOT_W + KW + REFL_W + 3 * POS_W;

    logic [INV_W-1:0] r_inv;
    logic [MAX_W-1:0] r_max;
    logic             w_clear_done;
    logic             w_fq_valid, w_fq_ready;
    logic [DW-1:0]    w_fq_data;
    logic             w_bq_valid, w_bq_ready;
    logic [DW-1:0]    w_bq_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= INV_RESET;
            r_max <= MAX_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_INV) begin
                r_inv <= i_cfg_data[INV_W-1:0];
            end else if (i_cfg_idx == REG_MAX) begin
                r_max <= i_cfg_data[MAX_W-1:0];
            end
        end
    end

    vgfp_front #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS),
        .SLOT_W      (SLOT_W),
        .KW          (KW),
        .DW          (DW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_reflect     (i_reflect),
        .i_point_valid (i_point_valid),
        .i_inv         (r_inv),
        .i_clear_done  (w_clear_done),
        .o_q_valid     (w_fq_valid),
        .i_q_ready     (w_fq_ready),
        .o_q_data      (w_fq_data)
    );

    vgfp_fifo #(
        .DW (DW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_data  (w_fq_data),
        .o_valid (w_bq_valid),
        .i_ready (w_bq_ready),
        .o_data  (w_bq_data)
    );

    vgfp_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS),
        .SLOT_W      (SLOT_W),
        .KW          (KW),
        .DW          (DW)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_bq_valid),
        .o_q_ready        (w_bq_ready),
        .i_q_data         (w_bq_data),
        .i_max            (r_max),
        .o_clear_done     (w_clear_done),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y),
        .o_out_z          (o_out_z),
        .o_out_reflect    (o_out_reflect),
        .o_occupied_count (o_occupied_count)
    );

endmodule
